// ----- hdl/json_string_unescape_utf8_core_macros.svh -----
// Assertion helpers for the unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH

// Same-cycle implication.
`define JSU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// Next-cycle implication.
`define JSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`endif

// ----- hdl/jsu_pkg.sv -----
`timescale 1ns / 1ps
package jsu_pkg;

    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [2:0] ERR_NO_QUOTE   = 3'd0;
    localparam logic [2:0] ERR_EARLY_END  = 3'd1;
    localparam logic [2:0] ERR_CTRL_CHAR  = 3'd2;
    localparam logic [2:0] ERR_BAD_ESC    = 3'd3;
    localparam logic [2:0] ERR_BAD_HEX    = 3'd4;
    localparam logic [2:0] ERR_NO_LOW     = 3'd5;
    localparam logic [2:0] ERR_BAD_LOW    = 3'd6;
    localparam logic [2:0] ERR_INCOMPLETE = 3'd7;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_BODY    = 4'd1,
        PH_ESC     = 4'd2,
        PH_HEX1    = 4'd3,
        PH_WANT_BS = 4'd4,
        PH_WANT_U  = 4'd5,
        PH_HEX2    = 4'd6
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [2:0] error_code;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [2:0] error_code;
    } res_t;

    // Up to four results caused by one input item.
    typedef struct packed {
        logic [2:0]      count;
        res_t [3:0]      res;
    } burst_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic res_t data_res(input logic [7:0] b);
        res_t r;
        r.kind       = KIND_DATA;
        r.out_byte   = b;
        r.error_code = 3'd0;
        return r;
    endfunction

    function automatic burst_t one_burst(input res_t r);
        burst_t bu;
        bu       = '0;
        bu.count = 3'd1;
        bu.res[0] = r;
        return bu;
    endfunction

    function automatic burst_t err_burst(input logic [2:0] code);
        res_t r;
        r.kind       = KIND_ERR;
        r.out_byte   = 8'h00;
        r.error_code = code;
        return one_burst(r);
    endfunction

    function automatic burst_t done_burst();
        res_t r;
        r.kind       = KIND_DONE;
        r.out_byte   = 8'h00;
        r.error_code = 3'd0;
        return one_burst(r);
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] v;
        if (c inside {[8'h30:8'h39]})
            v = {1'b1, 4'(c - 8'h30)};
        else if (c inside {[8'h61:8'h66]})
            v = {1'b1, 4'(c - 8'h57)};
        else if (c inside {[8'h41:8'h46]})
            v = {1'b1, 4'(c - 8'h37)};
        else
            v = 5'd0;
        return v;
    endfunction

    function automatic burst_t utf8_burst(input logic [20:0] cp);
        burst_t bu;
        bu = '0;
        if (cp <= 21'h7F)
        begin
            bu.count  = 3'd1;
            bu.res[0] = data_res({1'b0, cp[6:0]});
        end
        else if (cp <= 21'h7FF)
        begin
            bu.count  = 3'd2;
            bu.res[0] = data_res({3'b110, cp[10:6]});
            bu.res[1] = data_res({2'b10, cp[5:0]});
        end
        else if (cp <= 21'hFFFF)
        begin
            bu.count  = 3'd3;
            bu.res[0] = data_res({4'b1110, cp[15:12]});
            bu.res[1] = data_res({2'b10, cp[11:6]});
            bu.res[2] = data_res({2'b10, cp[5:0]});
        end
        else
        begin
            bu.count  = 3'd4;
            bu.res[0] = data_res({5'b11110, cp[20:18]});
            bu.res[1] = data_res({2'b10, cp[17:12]});
            bu.res[2] = data_res({2'b10, cp[11:6]});
            bu.res[3] = data_res({2'b10, cp[5:0]});
        end
        return bu;
    endfunction

endpackage

// ----- hdl/json_string_unescape_utf8_core.sv -----
`timescale 1ns / 1ps
// JSON string unescaper to UTF-8. Feed the bytes of one quoted string,
// opening quote first; in_end marks end of text. One input item is taken
// every cycle while the four-entry queue between the decoder and the output
// stage has room. Each input item yields zero to four results (a \uXXXX or
// surrogate pair yields up to four UTF-8 bytes), and the output stage
// delivers one result per cycle while out_ready is high, so sustained
// throughput is set by the output port: one result per cycle. out_valid for
// the first result of an item rises once its burst, written to the queue on
// the accepting edge, has been loaded into the output register; that load
// waits while earlier results are still pending.
// in_ready drops only while four undelivered bursts sit in the queue.
`include "json_string_unescape_utf8_core_macros.svh"
module json_string_unescape_utf8_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  jsu_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output jsu_pkg::out_item_t out_item
);

    jsu_pkg::q_status_t q_status;
    jsu_pkg::burst_t    push_burst;
    jsu_pkg::burst_t    head;
    logic               push;
    logic               pop;

    jsu_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_status (q_status),
        .push     (push),
        .burst    (push_burst)
    );

    jsu_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_burst),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    jsu_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    `JSU_ASSERT_IMPL(a_term_is_last, out_valid && out_item.kind != jsu_pkg::KIND_DATA, out_item.last)
    `JSU_ASSERT_IMPL(a_fields_clean, out_valid, (out_item.kind == jsu_pkg::KIND_DATA && out_item.error_code == 3'd0) || (out_item.kind == jsu_pkg::KIND_DONE && out_item.out_byte == 8'h00 && out_item.error_code == 3'd0) || (out_item.kind == jsu_pkg::KIND_ERR && out_item.out_byte == 8'h00))
    `JSU_ASSERT_NEXT(a_queue_drains, !q_status.empty && !out_valid, out_valid)

endmodule

// ----- hdl/jsu_front.sv -----
`timescale 1ns / 1ps
module jsu_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  jsu_pkg::in_item_t  in_item,
    input  jsu_pkg::q_status_t q_status,
    output logic               push,
    output jsu_pkg::burst_t    burst
);

    jsu_pkg::phase_t phase_reg, phase_next;
    logic [15:0]     hex_accum_reg, hex_accum_next;
    logic [1:0]      hex_count_reg, hex_count_next;
    logic [9:0]      high_sur_reg, high_sur_next;

    logic            accept;
    logic [7:0]      c;
    logic [4:0]      nib;
    logic [15:0]     acc_shift;
    logic [20:0]     pair_cp;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign c        = in_item.in_byte;
    assign nib      = jsu_pkg::hex_nibble(c);
    assign acc_shift = {hex_accum_reg[11:0], nib[3:0]};
    assign pair_cp  = 21'h10000 + {1'b0, high_sur_reg, acc_shift[9:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= jsu_pkg::PH_IDLE;
            hex_accum_reg <= '0;
            hex_count_reg <= '0;
            high_sur_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            hex_accum_reg <= hex_accum_next;
            hex_count_reg <= hex_count_next;
            high_sur_reg  <= high_sur_next;
        end
    end

    always_comb
    begin
        logic fail;
        fail           = 1'b0;
        phase_next     = phase_reg;
        hex_accum_next = hex_accum_reg;
        hex_count_next = hex_count_reg;
        high_sur_next  = high_sur_reg;
        burst          = '0;

        case (phase_reg)
            jsu_pkg::PH_BODY:
            begin
                if (in_item.in_end)
                begin
                    fail = 1'b1;
                    burst = jsu_pkg::err_burst(jsu_pkg::ERR_EARLY_END);
                end
                else if (c == jsu_pkg::CH_QUOTE)
                begin
                    burst = jsu_pkg::done_burst();
                    phase_next = jsu_pkg::PH_IDLE;
                end
                else if (c < jsu_pkg::CH_SPACE)
                begin
                    fail = 1'b1;
                    burst = jsu_pkg::err_burst(jsu_pkg::ERR_CTRL_CHAR);
                end
                else if (c == jsu_pkg::CH_BSL)
                    phase_next = jsu_pkg::PH_ESC;
                else
                    burst = jsu_pkg::one_burst(jsu_pkg::data_res(c));
            end
            jsu_pkg::PH_ESC:
            begin
                if (in_item.in_end)
                begin
                    fail = 1'b1;
                    burst = jsu_pkg::err_burst(jsu_pkg::ERR_EARLY_END);
                end
                else
                begin
                    phase_next = jsu_pkg::PH_BODY;
                    if (c inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH})
                        burst = jsu_pkg::one_burst(jsu_pkg::data_res(c));
                    else if (c == jsu_pkg::CH_B)
                        burst = jsu_pkg::one_burst(jsu_pkg::data_res(8'h08));
                    else if (c == jsu_pkg::CH_F)
                        burst = jsu_pkg::one_burst(jsu_pkg::data_res(8'h0C));
                    else if (c == jsu_pkg::CH_N)
                        burst = jsu_pkg::one_burst(jsu_pkg::data_res(8'h0A));
                    else if (c == jsu_pkg::CH_R)
                        burst = jsu_pkg::one_burst(jsu_pkg::data_res(8'h0D));
                    else if (c == jsu_pkg::CH_T)
                        burst = jsu_pkg::one_burst(jsu_pkg::data_res(8'h09));
                    else if (c == jsu_pkg::CH_U)
                    begin
                        phase_next     = jsu_pkg::PH_HEX1;
                        hex_accum_next = '0;
                        hex_count_next = '0;
                    end
                    else
                    begin
                        fail = 1'b1;
                        burst = jsu_pkg::err_burst(jsu_pkg::ERR_BAD_ESC);
                    end
                end
            end
            jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2:
            begin
                if (in_item.in_end)
                begin
                    fail = 1'b1;
                    burst = jsu_pkg::err_burst(jsu_pkg::ERR_INCOMPLETE);
                end
                else if (!nib[4])
                begin
                    fail = 1'b1;
                    burst = jsu_pkg::err_burst(jsu_pkg::ERR_BAD_HEX);
                end
                else if (hex_count_reg != 2'd3)
                begin
                    hex_accum_next = acc_shift;
                    hex_count_next = hex_count_reg + 2'd1;
                end
                else
                begin
                    hex_accum_next = '0;
                    hex_count_next = '0;
                    if (phase_reg == jsu_pkg::PH_HEX1)
                    begin
                        if (acc_shift >= 16'hD800 && acc_shift <= 16'hDBFF)
                        begin
                            high_sur_next = acc_shift[9:0];
                            phase_next    = jsu_pkg::PH_WANT_BS;
                        end
                        else
                        begin
                            burst      = jsu_pkg::utf8_burst({5'd0, acc_shift});
                            phase_next = jsu_pkg::PH_BODY;
                        end
                    end
                    else if (acc_shift < 16'hDC00 || acc_shift > 16'hDFFF)
                    begin
                        fail = 1'b1;
                        burst = jsu_pkg::err_burst(jsu_pkg::ERR_BAD_LOW);
                    end
                    else
                    begin
                        burst         = jsu_pkg::utf8_burst(pair_cp);
                        high_sur_next = '0;
                        phase_next    = jsu_pkg::PH_BODY;
                    end
                end
            end
            jsu_pkg::PH_WANT_BS:
            begin
                if (in_item.in_end)
                begin
                    fail = 1'b1;
                    burst = jsu_pkg::err_burst(jsu_pkg::ERR_EARLY_END);
                end
                else if (c == jsu_pkg::CH_BSL)
                    phase_next = jsu_pkg::PH_WANT_U;
                else
                begin
                    fail = 1'b1;
                    burst = jsu_pkg::err_burst(jsu_pkg::ERR_NO_LOW);
                end
            end
            jsu_pkg::PH_WANT_U:
            begin
                if (in_item.in_end)
                begin
                    fail = 1'b1;
                    burst = jsu_pkg::err_burst(jsu_pkg::ERR_EARLY_END);
                end
                else if (c == jsu_pkg::CH_U)
                begin
                    phase_next     = jsu_pkg::PH_HEX2;
                    hex_accum_next = '0;
                    hex_count_next = '0;
                end
                else
                begin
                    fail = 1'b1;
                    burst = jsu_pkg::err_burst(jsu_pkg::ERR_NO_LOW);
                end
            end
            default:
            begin
                if (in_item.in_end)
                begin
                    fail = 1'b1;
                    burst = jsu_pkg::err_burst(jsu_pkg::ERR_EARLY_END);
                end
                else if (c == jsu_pkg::CH_QUOTE)
                    phase_next = jsu_pkg::PH_BODY;
                else
                begin
                    fail = 1'b1;
                    burst = jsu_pkg::err_burst(jsu_pkg::ERR_NO_QUOTE);
                end
            end
        endcase

        if (fail)
        begin
            phase_next     = jsu_pkg::PH_IDLE;
            hex_accum_next = '0;
            hex_count_next = '0;
            high_sur_next  = '0;
        end
    end

    assign push = accept && (burst.count != 3'd0);

endmodule

// ----- hdl/jsu_queue.sv -----
`timescale 1ns / 1ps
module jsu_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  jsu_pkg::burst_t     push_data,
    input  logic                pop,
    output jsu_pkg::burst_t     head,
    output jsu_pkg::q_status_t  q_status
);

    jsu_pkg::burst_t                  mem_reg [jsu_pkg::Q_DEPTH];
    logic [jsu_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [jsu_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [jsu_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;
    logic                             do_push, do_pop;

    localparam logic [jsu_pkg::QPTR_W-1:0] PTR_LAST = jsu_pkg::QPTR_W'(jsu_pkg::Q_DEPTH - 1);
    localparam logic [jsu_pkg::QCNT_W-1:0] CNT_FULL = jsu_pkg::QCNT_W'(jsu_pkg::Q_DEPTH);

    assign q_status.full  = (cnt_reg == CNT_FULL);
    assign q_status.empty = (cnt_reg == '0);
    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- hdl/jsu_back.sv -----
`timescale 1ns / 1ps
module jsu_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  jsu_pkg::burst_t     head,
    input  jsu_pkg::q_status_t  q_status,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output jsu_pkg::out_item_t  out_item
);

    logic            cur_valid_reg, cur_valid_next;
    jsu_pkg::burst_t cur_reg, cur_next;
    logic [1:0]      idx_reg, idx_next;
    logic            is_last;
    logic            load;
    jsu_pkg::res_t   sel;

    assign is_last   = ({1'b0, idx_reg} + 3'd1) == cur_reg.count;
    assign load      = !cur_valid_reg || (out_ready && is_last);
    assign pop       = load && !q_status.empty;
    assign out_valid = cur_valid_reg;
    assign sel       = cur_reg.res[idx_reg];

    assign out_item.kind       = sel.kind;
    assign out_item.out_byte   = sel.out_byte;
    assign out_item.error_code = sel.error_code;
    assign out_item.last       = is_last;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            cur_valid_next = !q_status.empty;
            cur_next       = head;
            idx_next       = '0;
        end
        else if (out_ready)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule
